// ----- sv/sitda_pkg.sv -----
// sitda_pkg: shared types and constants for the signed integer to ascii converter
// no dependencies
`default_nettype none

package sitda_pkg;

    typedef logic [6:0] char_t;

    localparam char_t ASCII_ZERO  = 7'd48;
    localparam char_t ASCII_MINUS = 7'd45;

    // magnitude bits consumed by the double-dabble unit per cycle
    localparam int STEP_BITS = 4;

endpackage

`default_nettype wire

// ----- sv/sitda_queue.sv -----
// sitda_queue: small register queue between the front and back parts
// no dependencies
`default_nettype none

module sitda_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  rd_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/sitda_front.sv -----
// sitda_front: accepts input values, splits them into sign and magnitude
// feeds sitda_queue; no package dependencies
`default_nettype none

module sitda_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         push,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                         q_full,
    output logic                              wr_en,
    output logic [VALUE_BITS:0]               wr_data
);

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;

    // most negative value negates to itself, which is the right unsigned magnitude
    assign neg     = value[VALUE_BITS-1];
    assign mag     = neg ? (~value + 1'b1) : value;
    assign wr_en   = push && !q_full;
    assign wr_data = {neg, mag};

endmodule

`default_nettype wire

// ----- sv/sitda_back.sv -----
// sitda_back: binary to bcd conversion by double dabble, then character emission
// depends on sitda_pkg; reads entries from sitda_queue
`default_nettype none

module sitda_back
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [VALUE_BITS:0]   q_data,
    output logic                       q_pop,
    output char_t                      char_code,
    output logic                       last,
    output logic                       empty,
    input  wire logic                  pop
);

    localparam int CONV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int CONV_BITS   = CONV_CYCLES * STEP_BITS;
    localparam int NUM_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int DIG_W       = $clog2(NUM_DIGITS);
    localparam int CNT_W       = $clog2(CONV_CYCLES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_EMIT
    } state_t;

    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic [CONV_BITS-1:0] mag_reg,       mag_next;
    logic [BCD_W-1:0]     bcd_reg,       bcd_next;
    logic                 neg_reg,       neg_next;
    logic                 sign_pend_reg, sign_pend_next;
    logic [DIG_W-1:0]     ptr_reg,       ptr_next;
    logic                 valid_reg,     valid_next;
    char_t                char_reg,      char_next;
    logic                 last_reg,      last_next;

    logic [BCD_W-1:0]     bcd_step;
    logic [DIG_W-1:0]     msd;
    logic [3:0]           cur_digit;
    logic                 out_free;

    // shift STEP_BITS magnitude bits into the bcd register, add-3 before each shift
    always_comb
    begin
        bcd_step = bcd_reg;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_step[d*4 +: 4] >= 4'd5)
                begin
                    bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], mag_reg[CONV_BITS-1-s]};
        end
    end

    // highest nonzero digit; zero keeps the lowest digit
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                msd = DIG_W'(d);
            end
        end
    end

    assign cur_digit = 4'(bcd_reg >> {ptr_reg, 2'b00});
    assign out_free  = !valid_reg || pop;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        ptr_next       = ptr_reg;
        valid_next     = valid_reg && !pop;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    neg_next   = q_data[VALUE_BITS];
                    mag_next   = CONV_BITS'(q_data[VALUE_BITS-1:0]);
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_step;
                mag_next = mag_reg << STEP_BITS;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_CYCLES - 1))
                begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                ptr_next       = msd;
                sign_pend_next = neg_reg;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_next      = ASCII_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next = ASCII_ZERO + {3'b000, cur_digit};
                        last_next = (ptr_reg == '0);
                        if (ptr_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            ptr_reg       <= '0;
            valid_reg     <= 1'b0;
            char_reg      <= ASCII_ZERO;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mag_reg       <= mag_next;
            bcd_reg       <= bcd_next;
            neg_reg       <= neg_next;
            sign_pend_reg <= sign_pend_next;
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign char_code = char_reg;
    assign last      = last_reg;
    assign empty     = !valid_reg;

endmodule

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii.sv -----
// signed_int_to_decimal_ascii: top level, front part, two-entry queue and back part
// depends on sitda_pkg, sitda_front, sitda_queue, sitda_back
// each value is loaded from the queue, converted by the double-dabble unit and its
// leading digit found; then one character per cycle goes to the result port while
// pop keeps up; the back part takes the next value once its last character is out
// the queue takes up to two more values while one is being converted or emitted
// reset clears the queue, the sequencer and the result register; empty is high after reset
`default_nettype none

module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                         pop,
    output logic                              empty,
    output char_t                             char_code,
    output logic                              last
);

    logic                q_wr_en;
    logic [VALUE_BITS:0] q_wr_data;
    logic                q_full;
    logic                q_pop;
    logic [VALUE_BITS:0] q_rd_data;
    logic                q_valid;

    assign full = q_full;

    sitda_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .push    (push),
        .value   (value),
        .q_full  (q_full),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data)
    );

    sitda_queue #(
        .WIDTH(VALUE_BITS + 1),
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_rd_data),
        .rd_valid (q_valid)
    );

    sitda_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .char_code (char_code),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ----- sv/sitda_checker.sv -----
// sitda_checker: port-level checks for signed_int_to_decimal_ascii, bound to the top level
// depends on sitda_pkg
`default_nettype none

module sitda_checker
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         push,
    input wire logic                         full,
    input wire logic signed [VALUE_BITS-1:0] value,
    input wire logic                         pop,
    input wire logic                         empty,
    input wire char_t                        char_code,
    input wire logic                         last
);

    // a waiting result that is not taken stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(char_code) && $stable(last))
        else $error("result changed while stalled");

    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (char_code == ASCII_MINUS) ||
                   ((char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 7'd9)))
        else $error("result is not a minus sign or a digit");

    // a sign is always followed by at least one digit
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (char_code == ASCII_MINUS) |-> !last)
        else $error("minus sign marked as last");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    // an input transfer carries a fully known value
    a_value_known: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |-> !$isunknown(value))
        else $error("input transfer with unknown value");

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_sitda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .value     (value),
    .pop       (pop),
    .empty     (empty),
    .char_code (char_code),
    .last      (last)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// testbench for signed_int_to_decimal_ascii: random and directed values in, decimal text out
// depends on sitda_pkg and the signed_int_to_decimal_ascii rtl

import sitda_pkg::*;

typedef struct packed {
    char_t code;
    logic  last;
} text_char_t;

class char_scoreboard #(int WIDTH = 32);
    text_char_t expected_text[$];
    int         failures;

    function new();
        failures = 0;
    endfunction

    // works out the decimal text of an accepted value and queues its characters
    function void note_value(logic signed [WIDTH-1:0] v);
        logic [WIDTH-1:0] magnitude;
        logic [63:0]      rest;
        logic             negative;
        char_t            digits[$];
        text_char_t       entry;
        int               total;
        int               n;

        negative  = v[WIDTH-1];
        magnitude = negative ? -v : v;
        rest      = 64'(magnitude);
        do
        begin
            digits.push_front(char_t'(ASCII_ZERO + rest % 10));
            rest = rest / 10;
        end
        while (rest != 0);
        total = digits.size() + (negative ? 1 : 0);
        n = 0;
        if (negative)
        begin
            entry.code = ASCII_MINUS;
            entry.last = (total == 1);
            expected_text.push_back(entry);
            n++;
        end
        foreach (digits[k])
        begin
            entry.code = digits[k];
            entry.last = (n == total - 1);
            expected_text.push_back(entry);
            n++;
        end
    endfunction

    function void check_char(char_t code, logic last_flag);
        text_char_t want;
        if (expected_text.size() == 0)
        begin
            $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                     $time, code, last_flag);
            failures++;
            return;
        end
        want = expected_text.pop_front();
        if (code !== want.code)
        begin
            $display("%0t: char_code mismatch: expected %0d, actual %0d",
                     $time, want.code, code);
            failures++;
        end
        if (last_flag !== want.last)
        begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, last_flag);
            failures++;
        end
    endfunction

    function int pending();
        return expected_text.size();
    endfunction
endclass

module testbench;
    localparam int VALUE_BITS   = 32;
    localparam int RANDOM_ITEMS = 270;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT_CHAR = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic signed [VALUE_BITS-1:0] value;
    logic                         pop;
    logic                         empty;
    char_t                        char_code;
    logic                         last;

    char_scoreboard #(VALUE_BITS) text_board;
    bit send_burst;
    bit recv_burst;

    int directed_values[] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
        999999999, 1000000000, -1000000000, 2147483647, -2147483647,
        32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 7
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .value    (value),
        .pop      (pop),
        .empty    (empty),
        .char_code(char_code),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // wait count per item, with runs of back-to-back transfers now and then
    function automatic int draw_gap(ref bit burst);
        if ($urandom_range(0, 23) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    // spread values over all digit counts, plus some raw 32-bit patterns
    function automatic int pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n == 1)
            lo = 0;
        if (hi > 2147483647)
            hi = 2147483647;
        mag = lo + longint'({$urandom}) % (hi - lo + 1);
        return $urandom_range(0, 1) ? int'(-mag) : int'(mag);
    endfunction

    task automatic send_value(int v);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v[VALUE_BITS-1:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        text_board.note_value(value);
    endtask

    // result side: random pop gaps, one long hold-off to fill the block
    initial
    begin
        int  gap;
        int  chars_seen;
        bit  held;
        chars_seen = 0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(recv_burst);
            if (!held && chars_seen >= HOLD_AT_CHAR)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            text_board.check_char(char_code, last);
            chars_seen++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        value      = '0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        text_board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[k])
            send_value(directed_values[k]);
        repeat (RANDOM_ITEMS) send_value(pick_value());
        push <= 1'b0;

        while (text_board.pending() != 0)
            @(posedge clk);
        // anything extra the block emits now shows up as an unexpected char
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (text_board.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
